FILE: rtl/lbm_pkg.sv
// Shared types, constants and arithmetic helpers of the D2Q9 BGK node collision block.
// Used by every module under rtl; has no dependencies of its own.
package lbm_pkg;

    localparam int WORD = 32;
    localparam int FRAC = 28;
    localparam int NPOP = 9;
    localparam int RELAX_W = 30;
    localparam int QDEPTH = 4;
    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int DIV_STEPS = WORD;
    localparam int DEN_W = WORD - 1;
    localparam int WIDE = 72;

    localparam logic [RELAX_W-1:0] RELAX_RESET = RELAX_W'(1) << FRAC;

    // Division by nine of the scaled equilibrium magnitude, split in two halves
    localparam int X_W = WORD + 2;
    localparam int LO_W = X_W / 2;
    localparam int HI_W = X_W - LO_W;
    localparam int SH_A = HI_W + 4;
    localparam int Y_W = LO_W + 4;
    localparam int SH_B = Y_W + 4;
    localparam longint MA = ((64'sd1 <<< SH_A) + 64'sd8) / 64'sd9;
    localparam longint MB = ((64'sd1 <<< SH_B) + 64'sd8) / 64'sd9;
    localparam int MA_W = SH_A - 2;
    localparam int MB_W = SH_B - 2;

    localparam int DIR_X [NPOP] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NPOP] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

    typedef logic signed [WORD-1:0] word_t;
    typedef logic signed [2*WORD-1:0] prod_t;
    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct packed {
        word_t [NPOP-1:0] pop;
        word_t rho;
        word_t mx;
        word_t my;
    } node_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic ov;
        logic neg;
        logic [DEN_W-1:0] rem;
        logic [WORD-1:0] low;
        logic [WORD-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic dpos;
        logic [DEN_W-1:0] den;
        div_lane_t lx;
        div_lane_t ly;
        node_t node;
    } div_stage_t;

    localparam wide_t WMAX = (wide_t'(1) <<< (WORD - 1)) - wide_t'(1);
    localparam wide_t WMIN = -(wide_t'(1) <<< (WORD - 1));

    // Clamp a wide signed value to the word range
    function automatic word_t sat_word(input wide_t v);
        word_t r;
        if (v > WMAX)
        begin
            r = WMAX[WORD-1:0];
        end
        else if (v < WMIN)
        begin
            r = WMIN[WORD-1:0];
        end
        else
        begin
            r = v[WORD-1:0];
        end
        return r;
    endfunction

    // Fixed-point product back to a word: floor shift, then clamp
    function automatic word_t fx_round(input prod_t p);
        wide_t e;
        e = p;
        return sat_word(e >>> FRAC);
    endfunction

    // Signed contribution c * v with c in {-1, 0, 1}
    function automatic wide_t dir_term(input int c, input word_t v);
        wide_t e;
        e = v;
        if (c > 0)
        begin
            return e;
        end
        else if (c < 0)
        begin
            return -e;
        end
        return '0;
    endfunction

    // Second-order polynomial of the equilibrium, halved
    function automatic word_t poly_of(input word_t cu, input word_t cu2, input word_t usq);
        wide_t a;
        wide_t b;
        wide_t c;
        wide_t acc;
        a = cu;
        b = cu2;
        c = usq;
        acc = (wide_t'(2) <<< FRAC) + wide_t'(6) * a + wide_t'(9) * b - wide_t'(3) * c;
        return sat_word(acc >>> 1);
    endfunction

    // Set up one velocity division lane: magnitude of momentum shifted up by FRAC
    function automatic div_lane_t lane_init(input word_t mom, input logic [DEN_W-1:0] den);
        div_lane_t l;
        logic [WORD-1:0] mag;
        logic [WORD-1:0] hi;
        mag = mom[WORD-1] ? WORD'(-mom) : WORD'(mom);
        hi = mag >> (WORD - FRAC);
        l.ov = (hi >= WORD'(den));
        l.neg = mom[WORD-1];
        l.rem = hi[DEN_W-1:0];
        l.low = mag << FRAC;
        l.quo = '0;
        return l;
    endfunction

    // One restoring division step: one quotient bit
    function automatic div_lane_t lane_step(input div_lane_t l, input logic [DEN_W-1:0] den);
        div_lane_t r;
        logic [WORD-1:0] trial;
        r = l;
        trial = {l.rem, l.low[WORD-1]};
        r.low = l.low << 1;
        if (trial >= WORD'(den))
        begin
            r.rem = DEN_W'(trial - WORD'(den));
            r.quo = {l.quo[WORD-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DEN_W-1:0];
            r.quo = {l.quo[WORD-2:0], 1'b0};
        end
        return r;
    endfunction

    // Signed, saturated velocity from a finished division lane
    function automatic word_t lane_result(input div_lane_t l, input logic dpos);
        logic [WORD-1:0] lim;
        word_t r;
        lim = WORD'(1) << (WORD - 1);
        if (!dpos)
        begin
            r = '0;
        end
        else if (l.neg)
        begin
            r = (l.ov || l.quo > lim) ? WMIN[WORD-1:0] : word_t'(-l.quo);
        end
        else
        begin
            r = (l.ov || l.quo[WORD-1]) ? WMAX[WORD-1:0] : word_t'(l.quo);
        end
        return r;
    endfunction

    // Scale |rp| by nine times the weight, leaving a division by nine
    function automatic logic [X_W-1:0] weight_scale(input int i, input logic [WORD-1:0] m);
        logic [X_W-1:0] x;
        if (i == 0)
        begin
            x = X_W'(m) << 2;
        end
        else if (i < 5)
        begin
            x = X_W'(m);
        end
        else
        begin
            x = X_W'(m >> 2);
        end
        return x;
    endfunction

endpackage

FILE: rtl/lbm_front.sv
// Front end: takes node requests, forms density and momenta, hands nodes to the queue.
// Depends on lbm_pkg.
module lbm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [lbm_pkg::NPOP*lbm_pkg::WORD-1:0] s_tdata,
    input  lbm_pkg::q_stat_t     q_stat,
    output logic                 push,
    output lbm_pkg::node_t       push_node
);
    import lbm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    node_t node_reg;
    node_t node_next;
    logic  take;

    assign push      = valid_reg && !q_stat.full;
    assign s_tready  = !valid_reg || !q_stat.full;
    assign take      = s_tvalid && s_tready;
    assign push_node = node_reg;
    assign valid_next = take || (valid_reg && !push);

    // Sum populations into density and momenta
    always_comb
    begin
        wide_t sr;
        wide_t sx;
        wide_t sy;
        word_t f;
        sr = '0;
        sx = '0;
        sy = '0;
        node_next = '0;
        for (int i = 0; i < NPOP; i++)
        begin
            f = s_tdata[i*WORD +: WORD];
            node_next.pop[i] = f;
            sr = sr + dir_term(1, f);
            sx = sx + dir_term(DIR_X[i], f);
            sy = sy + dir_term(DIR_Y[i], f);
        end
        node_next.rho = sat_word(sr);
        node_next.mx  = sat_word(sx);
        node_next.my  = sat_word(sy);
    end

    // Hold the node until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            node_reg <= node_next;
        end
    end

endmodule

FILE: rtl/lbm_queue.sv
// Short node queue between the front end and the collision pipeline.
// Depends on lbm_pkg.
module lbm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lbm_pkg::node_t     push_node,
    input  logic               pop,
    output lbm_pkg::q_stat_t   q_stat,
    output lbm_pkg::node_t     head
);
    import lbm_pkg::*;

    node_t            mem [QDEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign head = mem[rd_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_next  = push ? PTR_W'((int'(wr_reg) + 1) % QDEPTH) : wr_reg;
        rd_next  = pop ? PTR_W'((int'(rd_reg) + 1) % QDEPTH) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_node;
        end
    end

endmodule

FILE: rtl/lbm_div.sv
// Velocity divider: momentum over density, one quotient bit per stage, both axes in step.
// Depends on lbm_pkg.
module lbm_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  lbm_pkg::node_t  in_node,
    output logic            out_valid,
    output lbm_pkg::node_t  out_node,
    output lbm_pkg::word_t  ux,
    output lbm_pkg::word_t  uy
);
    import lbm_pkg::*;

    div_stage_t             stg_reg [DIV_STEPS+1];
    div_stage_t             prep;
    logic [DIV_STEPS:0]     vld_reg;

    // Prepare divisor and both lanes; non-positive density divides by one
    always_comb
    begin
        prep.node = in_node;
        prep.dpos = !in_node.rho[WORD-1] && (in_node.rho != '0);
        prep.den  = prep.dpos ? in_node.rho[DEN_W-1:0] : DEN_W'(1);
        prep.lx   = lane_init(in_node.mx, prep.den);
        prep.ly   = lane_init(in_node.my, prep.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    // Advance every stage by one quotient bit
    always_ff @(posedge clk)
    begin
        div_stage_t stg;
        if (en)
        begin
            stg_reg[0] <= prep;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                stg    = stg_reg[k];
                stg.lx = lane_step(stg_reg[k].lx, stg_reg[k].den);
                stg.ly = lane_step(stg_reg[k].ly, stg_reg[k].den);
                stg_reg[k+1] <= stg;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_node  = stg_reg[DIV_STEPS].node;
    assign ux = lane_result(stg_reg[DIV_STEPS].lx, stg_reg[DIV_STEPS].dpos);
    assign uy = lane_result(stg_reg[DIV_STEPS].ly, stg_reg[DIV_STEPS].dpos);

endmodule

FILE: rtl/lbm_back.sv
// Back end: equilibrium and BGK relaxation pipeline with the result register.
// Depends on lbm_pkg and lbm_div.
module lbm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [lbm_pkg::RELAX_W-1:0] relax_rate,
    input  lbm_pkg::q_stat_t       q_stat,
    input  lbm_pkg::node_t         head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [(lbm_pkg::NPOP+3)*lbm_pkg::WORD-1:0] m_tdata
);
    import lbm_pkg::*;

    typedef struct packed {
        node_t node;
        word_t ux;
        word_t uy;
    } carry_t;

    logic   adv;
    logic   dv_valid;
    node_t  dv_node;
    word_t  dv_ux;
    word_t  dv_uy;

    logic   va_reg, vb_reg, vc_reg, vd_reg, ve1_reg, ve2_reg, ve3_reg, vf_reg, out_valid_reg;
    carry_t ca_reg, cb_reg, cc_reg, cd_reg, ce1_reg, ce2_reg, ce3_reg, cf_reg;

    prod_t  psx_reg;
    prod_t  psy_reg;
    word_t  cua_reg [NPOP];
    word_t  usq_reg;
    word_t  cub_reg [NPOP];
    prod_t  cu2p_reg [NPOP];
    word_t  poly_reg [NPOP];
    prod_t  rpp_reg [NPOP];
    logic [HI_W-1:0] a_reg [NPOP];
    logic [LO_W-1:0] b_reg [NPOP];
    logic [HI_W-1:0] qa1_reg [NPOP];
    logic            n1_reg [NPOP];
    logic [HI_W-1:0] qa2_reg [NPOP];
    logic [Y_W+MB_W-1:0] yp_reg [NPOP];
    logic            n2_reg [NPOP];
    word_t  feq_reg [NPOP];
    prod_t  pf_reg [NPOP];
    prod_t  pe_reg [NPOP];
    logic [(NPOP+3)*WORD-1:0] out_reg;

    word_t  one_minus;
    word_t  omega;

    // Whole back end moves together whenever the result register frees up
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !q_stat.empty;
    assign omega = word_t'({{(WORD-RELAX_W){1'b0}}, relax_rate});
    assign one_minus = (word_t'(1) <<< FRAC) - omega;

    lbm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (!q_stat.empty),
        .in_node   (head),
        .out_valid (dv_valid),
        .out_node  (dv_node),
        .ux        (dv_ux),
        .uy        (dv_uy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve1_reg <= 1'b0;
            ve2_reg <= 1'b0;
            ve3_reg <= 1'b0;
            vf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= dv_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve1_reg <= vd_reg;
            ve2_reg <= ve1_reg;
            ve3_reg <= ve2_reg;
            vf_reg <= ve3_reg;
            out_valid_reg <= vf_reg;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        logic [WORD-1:0] mag;
        logic [X_W-1:0]  x;
        logic [HI_W+MA_W-1:0] pa;
        logic [Y_W-1:0]  y;
        logic [3:0]      ra;
        logic [LO_W-1:0] qb;
        logic [X_W-1:0]  q;
        wide_t           acc;
        wide_t           e1;
        wide_t           e2;
        if (adv)
        begin
            // Squares of velocity and projections on each direction
            ca_reg <= '{node: dv_node, ux: dv_ux, uy: dv_uy};
            psx_reg <= prod_t'(dv_ux) * prod_t'(dv_ux);
            psy_reg <= prod_t'(dv_uy) * prod_t'(dv_uy);
            for (int i = 0; i < NPOP; i++)
            begin
                cua_reg[i] <= sat_word(dir_term(DIR_X[i], dv_ux) + dir_term(DIR_Y[i], dv_uy));
            end

            // Speed squared and projection squares
            cb_reg <= ca_reg;
            e1 = fx_round(psx_reg);
            e2 = fx_round(psy_reg);
            usq_reg <= sat_word(e1 + e2);
            for (int i = 0; i < NPOP; i++)
            begin
                cub_reg[i]  <= cua_reg[i];
                cu2p_reg[i] <= prod_t'(cua_reg[i]) * prod_t'(cua_reg[i]);
            end

            // Equilibrium polynomial
            cc_reg <= cb_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                poly_reg[i] <= poly_of(cub_reg[i], fx_round(cu2p_reg[i]), usq_reg);
            end

            // Density times polynomial
            cd_reg <= cc_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                rpp_reg[i] <= prod_t'(cc_reg.node.rho) * prod_t'(poly_reg[i]);
            end

            // Weight and upper half of the division by nine
            ce1_reg <= cd_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                word_t rp;
                rp = fx_round(rpp_reg[i]);
                mag = rp[WORD-1] ? WORD'(-rp) : WORD'(rp);
                x = weight_scale(i, mag);
                pa = (HI_W+MA_W)'(x[X_W-1:LO_W]) * (HI_W+MA_W)'(MA);
                a_reg[i]   <= x[X_W-1:LO_W];
                b_reg[i]   <= x[LO_W-1:0];
                qa1_reg[i] <= HI_W'(pa >> SH_A);
                n1_reg[i]  <= rp[WORD-1];
            end

            // Lower half of the division by nine
            ce2_reg <= ce1_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                ra = 4'(a_reg[i] - HI_W'(9) * qa1_reg[i]);
                y = {ra, b_reg[i]};
                yp_reg[i]  <= (Y_W+MB_W)'(y) * (Y_W+MB_W)'(MB);
                qa2_reg[i] <= qa1_reg[i];
                n2_reg[i]  <= n1_reg[i];
            end

            // Assemble signed equilibrium
            ce3_reg <= ce2_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                qb = LO_W'(yp_reg[i] >> SH_B);
                q = {qa2_reg[i], {LO_W{1'b0}}} + X_W'(qb);
                feq_reg[i] <= n2_reg[i] ? word_t'(-q[WORD-1:0]) : word_t'(q[WORD-1:0]);
            end

            // Relaxation products
            cf_reg <= ce3_reg;
            for (int i = 0; i < NPOP; i++)
            begin
                pf_reg[i] <= prod_t'(one_minus) * prod_t'(word_t'(ce3_reg.node.pop[i]));
                pe_reg[i] <= prod_t'(omega) * prod_t'(feq_reg[i]);
            end

            // Result register
            for (int i = 0; i < NPOP; i++)
            begin
                e1 = pf_reg[i];
                e2 = pe_reg[i];
                acc = e1 + e2;
                out_reg[i*WORD +: WORD] <= sat_word(acc >>> FRAC);
            end
            out_reg[NPOP*WORD +: WORD]     <= cf_reg.node.rho;
            out_reg[(NPOP+1)*WORD +: WORD] <= cf_reg.ux;
            out_reg[(NPOP+2)*WORD +: WORD] <= cf_reg.uy;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: rtl/d2q9_bgk_node_collide.sv
// Top level of the D2Q9 BGK node collision block.
// Depends on lbm_pkg, lbm_front, lbm_queue and lbm_back (which holds lbm_div).
//
// One lattice node enters per request and one result leaves per node, in order, at up
// to one node per clock while the output is not held. From input request to result a
// node passes the front register holding its density and momentum sums, the queue,
// the bit-serial velocity divider (one quotient bit per stage) and the equilibrium
// and relaxation stages up to and including the result register. A four-entry queue
// lets input keep flowing while the output is held, until the queue is full.
// relax_rate is omega in Q2.28, reset to 1.0; write it only while no node is in flight.
module d2q9_bgk_node_collide (
    input  logic         clk,
    input  logic         rst_n,
    // relax_rate
    input  logic         relax_we,
    input  logic [29:0]  relax_wdata,
    // s_tdata, low bits up: pop_rest, pop_east, pop_north, pop_west, pop_south,
    // pop_northeast, pop_northwest, pop_southwest, pop_southeast
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,
    // m_tdata, low bits up: new_rest, new_east, new_north, new_west, new_south,
    // new_northeast, new_northwest, new_southwest, new_southeast, density,
    // velocity_x, velocity_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [383:0] m_tdata
);
    import lbm_pkg::*;

    logic [RELAX_W-1:0] relax_rate_reg;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    node_t   push_node;
    node_t   head;

    // Hold the relaxation rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relax_rate_reg <= RELAX_RESET;
        end
        else if (relax_we)
        begin
            relax_rate_reg <= relax_wdata;
        end
    end

    lbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_node (push_node)
    );

    lbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_node (push_node),
        .pop       (pop),
        .q_stat    (q_stat),
        .head      (head)
    );

    lbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .relax_rate (relax_rate_reg),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: rtl/lbm_checker.sv
// Port-level checks of the D2Q9 BGK node collision block, bound to the top level.
// Depends on lbm_pkg.
module lbm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [383:0] m_tdata
);
    import lbm_pkg::*;

    localparam int MAX_INFLIGHT = 64;

    logic [7:0] occ_reg;
    logic [7:0] occ_next;
    logic       in_req;
    logic       out_req;
    word_t      dens;

    assign in_req  = s_tvalid && s_tready;
    assign out_req = m_tvalid && m_tready;
    assign dens    = m_tdata[NPOP*WORD +: WORD];
    assign occ_next = occ_reg + 8'(in_req) - 8'(out_req);

    // Track requests in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ_reg != 8'd0)
        else $error("result without a pending node");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 8'(MAX_INFLIGHT))
        else $error("too many nodes in flight");

    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (dens[WORD-1] || dens == '0) |->
            m_tdata[(NPOP+1)*WORD +: WORD] == '0 && m_tdata[(NPOP+2)*WORD +: WORD] == '0)
        else $error("velocity not zero for non-positive density");

endmodule

bind d2q9_bgk_node_collide lbm_checker u_lbm_checker (.*);
